>>> hdl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants for the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffsa_pkg;
  localparam int ADDR_W = 24;
  localparam int LEN_W = 25;
  localparam int ALIGN_W = 17;
  localparam int STAT_W = 2;
  localparam int ENTRY_W = ADDR_W + LEN_W + 1;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0] length;
    logic free;
  } seg_t;
endpackage
`default_nettype wire

>>> hdl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/ffsa_pad.sv
// ----------------------------------------------------------------------------
// ffsa_pad
// Sequential remainder unit: computes start mod align one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ffsa_pad
  import ffsa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic [ADDR_W-1:0]   dividend,
  input  wire logic [ALIGN_W-1:0]  divisor,
  output logic                     done,
  output logic      [ALIGN_W-1:0]  pad
);
  logic [ALIGN_W:0] rem_r, rem_nxt;
  logic [ADDR_W-1:0] num_r, num_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [ALIGN_W:0] shifted;
  logic [ALIGN_W:0] rem_fin;

  always_comb begin
    shifted = {rem_r[ALIGN_W-1:0], num_r[ADDR_W-1]};
    rem_nxt = rem_r;
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      num_nxt = dividend;
      cnt_nxt = 5'(ADDR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
      num_nxt = {num_r[ADDR_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign rem_fin = rem_r;
  assign done = done_r;
  assign pad = (rem_fin == '0) ? '0 : divisor - rem_fin[ALIGN_W-1:0];
endmodule
`default_nettype wire

>>> hdl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator with coalescing over one page; segment table in RAM.
// ----------------------------------------------------------------------------
// Channel  Ports                                        Handshake
// in       in_func in_alloc_size in_alignment in_free_address  start & !busy
// out      out_result_address out_status                out_valid, one cycle
//
// Each table entry passed over is read in S_RD and checked in S_CHK; a free
// entry is also checked for fit, which waits on the bit-serial remainder unit.
// Shifting entries to insert or remove a segment reads and writes each entry.
// After reset the S_INIT state writes the initial entry 0 before busy falls.
// The receiver cannot stall; a result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int PAGE_BYTES = 16777216
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_func,
  input  wire logic [LEN_W-1:0]    in_alloc_size,
  input  wire logic [ALIGN_W-1:0]  in_alignment,
  input  wire logic [ADDR_W-1:0]   in_free_address,
  output logic                     out_valid,
  output logic      [ADDR_W-1:0]   out_result_address,
  output logic      [STAT_W-1:0]   out_status
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RD = 5'd2;
  localparam logic [4:0] S_CHK = 5'd3;
  localparam logic [4:0] S_PADW = 5'd4;
  localparam logic [4:0] S_FIT = 5'd5;
  localparam logic [4:0] S_PREVR = 5'd6;
  localparam logic [4:0] S_PREVW = 5'd7;
  localparam logic [4:0] S_INSR = 5'd8;
  localparam logic [4:0] S_INSW = 5'd9;
  localparam logic [4:0] S_SPLIT = 5'd10;
  localparam logic [4:0] S_DONE = 5'd11;
  localparam logic [4:0] S_FNXR = 5'd12;
  localparam logic [4:0] S_FNXC = 5'd13;
  localparam logic [4:0] S_DELR = 5'd14;
  localparam logic [4:0] S_DELW = 5'd15;
  localparam logic [4:0] S_FPVR = 5'd16;
  localparam logic [4:0] S_FPVC = 5'd17;
  localparam logic [4:0] S_FRD = 5'd18;

  logic [4:0] st_r, st_nxt;
  logic [4:0] ret_r, ret_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic [CW-1:0] del_r, del_nxt;
  logic func_r, func_nxt;
  logic [LEN_W-1:0] size_r, size_nxt;
  logic [ALIGN_W-1:0] align_r, align_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  seg_t cur_r, cur_nxt;
  logic [ALIGN_W-1:0] pad_r, pad_nxt;
  logic ov_r, ov_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;

  logic we;
  logic [IW-1:0] waddr, raddr;
  seg_t wdata, rdata;
  logic pgo, pdone;
  logic [ALIGN_W-1:0] pad;
  logic [LEN_W:0] need;
  logic [LEN_W-1:0] rest;

  ffsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ffsa_pad u_pad (
    .clk(clk), .rst_n(rst_n), .go(pgo), .dividend(rdata.start),
    .divisor(align_r), .done(pdone), .pad(pad)
  );

  always_comb begin
    need = {1'b0, size_r} + (LEN_W+1)'(pad_r);
    rest = cur_r.length - LEN_W'(pad_r);
  end

  always_comb begin
    st_nxt = st_r;
    ret_nxt = ret_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    sh_nxt = sh_r;
    del_nxt = del_r;
    func_nxt = func_r;
    size_nxt = size_r;
    align_nxt = align_r;
    faddr_nxt = faddr_r;
    cur_nxt = cur_r;
    pad_nxt = pad_r;
    ov_nxt = 1'b0;
    oaddr_nxt = oaddr_r;
    ostat_nxt = ostat_r;
    we = 1'b0;
    waddr = IW'(idx_r);
    wdata = cur_r;
    raddr = IW'(idx_r);
    pgo = 1'b0;
    unique case (st_r)
      S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata.start = '0;
        wdata.length = LEN_W'(PAGE_BYTES);
        wdata.free = 1'b1;
        cnt_nxt = CW'(1);
        st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          size_nxt = in_alloc_size;
          align_nxt = (in_alignment == '0) ? ALIGN_W'(1) : in_alignment;
          faddr_nxt = in_free_address;
          idx_nxt = '0;
          st_nxt = S_RD;
        end
      end
      S_RD: begin
        if (idx_r >= cnt_r) begin
          oaddr_nxt = '0;
          ostat_nxt = (func_r == FUNC_FREE) ? ST_NOTFOUND : ST_NOFIT;
          st_nxt = S_DONE;
        end else begin
          raddr = IW'(idx_r);
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cur_nxt = rdata;
        if (func_r == FUNC_FREE) begin
          if (rdata.start == faddr_r) begin
            cur_nxt.free = 1'b1;
            st_nxt = S_FNXR;
          end else begin
            idx_nxt = idx_r + CW'(1);
            st_nxt = S_RD;
          end
        end else if (!rdata.free) begin
          idx_nxt = idx_r + CW'(1);
          st_nxt = S_RD;
        end else begin
          pgo = 1'b1;
          st_nxt = S_PADW;
        end
      end
      S_PADW: begin
        if (pdone) begin
          pad_nxt = pad;
          st_nxt = S_FIT;
        end
      end
      S_FIT: begin
        if ({1'b0, cur_r.length} < need) begin
          idx_nxt = idx_r + CW'(1);
          st_nxt = S_RD;
        end else if (rest != size_r && cnt_r >= CW'(MAX_SEGMENTS)) begin
          oaddr_nxt = '0;
          ostat_nxt = ST_FULL;
          st_nxt = S_DONE;
        end else begin
          cur_nxt.free = 1'b0;
          cur_nxt.start = cur_r.start + ADDR_W'(pad_r);
          cur_nxt.length = rest;
          sh_nxt = cnt_r;
          st_nxt = (idx_r != '0) ? S_PREVR : S_INSR;
        end
      end
      S_PREVR: begin
        raddr = IW'(idx_r - CW'(1));
        st_nxt = S_PREVW;
      end
      S_PREVW: begin
        we = 1'b1;
        waddr = IW'(idx_r - CW'(1));
        wdata = rdata;
        wdata.length = rdata.length + LEN_W'(pad_r);
        st_nxt = S_INSR;
      end
      S_INSR: begin
        if (cur_r.length == size_r) begin
          we = 1'b1;
          oaddr_nxt = cur_r.start;
          ostat_nxt = ST_OK;
          st_nxt = S_DONE;
        end else if (sh_r > idx_r + CW'(1)) begin
          raddr = IW'(sh_r - CW'(1));
          st_nxt = S_INSW;
        end else begin
          st_nxt = S_SPLIT;
        end
      end
      S_INSW: begin
        we = 1'b1;
        waddr = IW'(sh_r);
        wdata = rdata;
        sh_nxt = sh_r - CW'(1);
        st_nxt = S_INSR;
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = IW'(idx_r + CW'(1));
        wdata.start = cur_r.start + ADDR_W'(size_r);
        wdata.length = cur_r.length - size_r;
        wdata.free = 1'b1;
        cur_nxt.length = size_r;
        cnt_nxt = cnt_r + CW'(1);
        st_nxt = S_INSR;
      end
      S_FNXR: begin
        if (idx_r + CW'(1) < cnt_r) begin
          raddr = IW'(idx_r + CW'(1));
          st_nxt = S_FNXC;
        end else begin
          st_nxt = S_FPVR;
        end
      end
      S_FNXC: begin
        if (rdata.free) begin
          cur_nxt.length = cur_r.length + rdata.length;
          del_nxt = idx_r + CW'(1);
          ret_nxt = S_FPVR;
          st_nxt = S_DELR;
        end else begin
          st_nxt = S_FPVR;
        end
      end
      S_FPVR: begin
        if (idx_r != '0) begin
          raddr = IW'(idx_r - CW'(1));
          st_nxt = S_FPVC;
        end else begin
          we = 1'b1;
          oaddr_nxt = '0;
          ostat_nxt = ST_OK;
          st_nxt = S_DONE;
        end
      end
      S_FPVC: begin
        if (rdata.free) begin
          cur_nxt = rdata;
          cur_nxt.length = rdata.length + cur_r.length;
          idx_nxt = idx_r - CW'(1);
          del_nxt = idx_r;
          ret_nxt = S_FRD;
          st_nxt = S_DELR;
        end else begin
          we = 1'b1;
          oaddr_nxt = '0;
          ostat_nxt = ST_OK;
          st_nxt = S_DONE;
        end
      end
      S_FRD: begin
        we = 1'b1;
        oaddr_nxt = '0;
        ostat_nxt = ST_OK;
        st_nxt = S_DONE;
      end
      S_DELR: begin
        if (del_r + CW'(1) < cnt_r) begin
          raddr = IW'(del_r + CW'(1));
          st_nxt = S_DELW;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt = ret_r;
        end
      end
      S_DELW: begin
        we = 1'b1;
        waddr = IW'(del_r);
        wdata = rdata;
        del_nxt = del_r + CW'(1);
        st_nxt = S_DELR;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      ov_r <= 1'b0;
      cnt_r <= CW'(1);
      ret_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      cnt_r <= cnt_nxt;
      ret_r <= ret_nxt;
    end
    idx_r <= idx_nxt;
    sh_r <= sh_nxt;
    del_r <= del_nxt;
    func_r <= func_nxt;
    size_r <= size_nxt;
    align_r <= align_nxt;
    faddr_r <= faddr_nxt;
    cur_r <= cur_nxt;
    pad_r <= pad_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_result_address = oaddr_r;
  assign out_status = ostat_r;
endmodule
`default_nettype wire
